/* hw/rtl/base32_stream_encoder_defines.svh */
// Assertion macros shared by the base32 stream encoder RTL.
`ifndef BASE32_STREAM_ENCODER_DEFINES_SVH
`define BASE32_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B32E_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("b32e assertion failed");

// Next-cycle implication, checked outside reset.
`define B32E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("b32e assertion failed");

`endif

/* hw/rtl/b32e_pkg.sv */
// Types, constants and alphabet functions of the base32 stream encoder.
package b32e_pkg;

  localparam int unsigned AddrW        = 6;
  localparam int unsigned DataW        = 64;
  localparam int unsigned QueueDepthDef = 4;

  // register indexes (byte address = 8 * index)
  localparam logic [2:0] RegAlphaSel = 3'd0;
  localparam logic [2:0] RegCustom0  = 3'd1;
  localparam logic [2:0] RegCustom1  = 3'd2;
  localparam logic [2:0] RegCustom2  = 3'd3;
  localparam logic [2:0] RegCustom3  = 3'd4;
  localparam logic [2:0] RegPadChar  = 3'd5;

  // alphabet selector codes; bit 1 set means custom
  localparam logic [1:0] AlphaStd         = 2'd0;
  localparam logic [1:0] AlphaHex         = 2'd1;
  localparam logic [1:0] AlphaCustom      = 2'd2;
  localparam logic [1:0] AlphaCustomAlias = 2'd3;

  localparam logic [7:0] PadCharReset = 8'h3d;
  localparam logic [7:0] CharUpperA   = 8'h41;
  localparam logic [7:0] CharDigit0   = 8'h30;
  localparam logic [7:0] CharDigit2   = 8'h32;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } b32e_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } b32e_out_t;

  // one command per accepted byte: data symbols, then pad characters
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic [4:0] sym2;
    logic [1:0] ndata;
    logic [2:0] npad;
    logic       last;
  } b32e_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b32e_qstat_t;

  typedef struct packed {
    logic [2:0] leftover_count;
    logic [2:0] group_position;
  } b32e_fstat_t;

  typedef struct packed {
    logic [1:0]       alpha_sel;
    logic [3:0][63:0] custom;
    logic [7:0]       pad_char;
  } b32e_cfg_t;

  function automatic logic [7:0] std_char(logic [4:0] s);
    if (s < 5'd26) return CharUpperA + {3'b000, s};
    return CharDigit2 + {3'b000, s - 5'd26};
  endfunction

  function automatic logic [7:0] hex_char(logic [4:0] s);
    if (s < 5'd10) return CharDigit0 + {3'b000, s};
    return CharUpperA + {3'b000, s - 5'd10};
  endfunction

endpackage

/* hw/rtl/base32_stream_encoder.sv */
// Top level of the base32 stream encoder: register port, front end, queue, back end.
// Base32 (RFC 4648) encoder. Each accepted byte turns into one or two
// characters, and the byte marked last also yields the leftover-bit character
// and the pad characters up to a multiple of eight; the final character has
// last_char set. The output side delivers one character per cycle from its
// output register while out_stall_i is low, so the throughput of a long message
// is bounded by that back end; the front end takes a byte in any cycle in which
// the QueueDepth-entry command queue has room. A byte's command is written into
// the queue, and its first character is then loaded from the queue head into
// the output register. The alphabet and pad character come from 64-bit
// registers at byte addresses 8*index; write them only while the encoder is
// idle.
`include "base32_stream_encoder_defines.svh"

module base32_stream_encoder import b32e_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  b32e_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output b32e_out_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [1:0]       alpha_sel_q;
  logic [3:0][63:0] custom_q;
  logic [7:0]       pad_q;
  logic [2:0]       reg_idx;
  logic             wr_en, in_accept, pop;
  b32e_cfg_t        cfg;
  b32e_cmd_t        cmd_push, cmd_head;
  b32e_qstat_t      qstat;
  b32e_fstat_t      fstat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_sel_q <= AlphaStd;
      custom_q    <= '0;
      pad_q       <= PadCharReset;
    end else if (wr_en) begin
      unique case (reg_idx) inside
        RegAlphaSel: alpha_sel_q <= pwdata[1:0];
        RegCustom0, RegCustom1, RegCustom2, RegCustom3:
          custom_q[2'(reg_idx - RegCustom0)] <= pwdata;
        RegPadChar:  pad_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx) inside
      RegAlphaSel: prdata = {62'd0, alpha_sel_q};
      RegCustom0, RegCustom1, RegCustom2, RegCustom3:
        prdata = custom_q[2'(reg_idx - RegCustom0)];
      RegPadChar:  prdata = {56'd0, pad_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg.alpha_sel = alpha_sel_q;
  assign cfg.custom    = custom_q;
  assign cfg.pad_char  = pad_q;

  assign in_stall_o = qstat.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  b32e_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_data_i (in_data_i),
    .cmd_o     (cmd_push),
    .status_o  (fstat)
  );

  b32e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_accept),
    .cmd_i    (cmd_push),
    .pop_i    (pop),
    .cmd_o    (cmd_head),
    .status_o (qstat)
  );

  b32e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // leftover bits never exceed one partial symbol
  `B32E_ASSERT_IMPL(a_leftover_range, clk_i, rst_ni, 1'b1, fstat.leftover_count <= 3'd4)
  // a final byte leaves the packer at a group boundary with nothing left over
  `B32E_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_accept && in_data_i.last_byte,
                    fstat.leftover_count == 3'd0 && fstat.group_position == 3'd0)
  // the emitter only retires a command that is present
  `B32E_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, !qstat.empty)

endmodule

/* hw/rtl/b32e_front.sv */
// Front end: packs bytes into 5-bit symbols and builds one command per byte.
module b32e_front import b32e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  b32e_in_t    in_data_i,
  output b32e_cmd_t   cmd_o,
  output b32e_fstat_t status_o
);

  logic [3:0]  bits_q, bits_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  gp_q, gp_d;
  logic [11:0] acc, aligned;
  logic        two_groups;
  logic [2:0]  rem;
  logic [1:0]  ndata;
  logic [2:0]  gp_after;

  always_comb begin
    acc        = {bits_q, in_data_i.byte_in};
    // left-align the valid bits; bits below them are zero
    aligned    = 12'(acc << (3'd4 - cnt_q));
    two_groups = (cnt_q >= 3'd2);
    rem        = two_groups ? 3'(cnt_q - 3'd2) : 3'(cnt_q + 3'd3);
    ndata      = two_groups ? 2'd2 : 2'd1;
    if (in_data_i.last_byte && rem != 3'd0) ndata = ndata + 2'd1;
    gp_after   = gp_q + {1'b0, ndata};

    cmd_o.sym0  = aligned[11:7];
    cmd_o.sym1  = aligned[6:2];
    cmd_o.sym2  = {aligned[1:0], 3'b000};
    cmd_o.ndata = ndata;
    cmd_o.npad  = in_data_i.last_byte ? 3'(3'd0 - gp_after) : 3'd0;
    cmd_o.last  = in_data_i.last_byte;

    if (in_data_i.last_byte) begin
      bits_d = 4'd0;
      cnt_d  = 3'd0;
      gp_d   = 3'd0;
    end else begin
      bits_d = acc[3:0] & ~(4'hf << rem);
      cnt_d  = rem;
      gp_d   = gp_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= 4'd0;
      cnt_q  <= 3'd0;
      gp_q   <= 3'd0;
    end else if (accept_i) begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      gp_q   <= gp_d;
    end
  end

  assign status_o.leftover_count = cnt_q;
  assign status_o.group_position = gp_q;

endmodule

/* hw/rtl/b32e_queue.sv */
// Command FIFO between the front end and the character emitter.
module b32e_queue import b32e_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  b32e_cmd_t   cmd_i,
  input  logic        pop_i,
  output b32e_cmd_t   cmd_o,
  output b32e_qstat_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b32e_cmd_t       mem [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign cmd_o           = mem[rd_q];
  assign status_o.full   = (cnt_q == CntW'(Depth));
  assign status_o.empty  = (cnt_q == '0);

endmodule

/* hw/rtl/b32e_back.sv */
// Back end: walks commands, maps symbols via alphabet, one char/cycle unless stalled.
module b32e_back import b32e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  b32e_cfg_t   cfg_i,
  input  b32e_cmd_t   cmd_i,
  input  b32e_qstat_t qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output b32e_out_t   out_data_o
);

  logic       valid_q;
  b32e_out_t  out_q, out_d;
  logic [3:0] idx_q;
  logic [3:0] total;
  logic       at_end, load;
  logic [4:0] sym;
  logic [7:0] alpha_char;

  always_comb begin
    total  = {2'b00, cmd_i.ndata} + {1'b0, cmd_i.npad};
    at_end = (idx_q == 4'(total - 4'd1));
    load   = !valid_q || !out_stall_i;
    pop_o  = load && !qstat_i.empty && at_end;

    case (idx_q)
      4'd0:    sym = cmd_i.sym0;
      4'd1:    sym = cmd_i.sym1;
      default: sym = cmd_i.sym2;
    endcase

    unique case (cfg_i.alpha_sel) inside
      AlphaStd: alpha_char = std_char(sym);
      AlphaHex: alpha_char = hex_char(sym);
      AlphaCustom, AlphaCustomAlias:
        alpha_char = cfg_i.custom[sym[4:3]][{sym[2:0], 3'b000} +: 8];
      default:  alpha_char = std_char(sym);
    endcase

    out_d.char_out  = (idx_q < {2'b00, cmd_i.ndata}) ? alpha_char : cfg_i.pad_char;
    out_d.last_char = cmd_i.last && at_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 4'd0;
    end else if (load) begin
      valid_q <= !qstat_i.empty;
      if (!qstat_i.empty) idx_q <= at_end ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !qstat_i.empty) out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule
